FILE: src/rri_pkg.sv
`default_nettype none

package rri_pkg;

    // configuration port
    localparam int CFG_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 40;

    // ray parameter, unsigned Q16.16
    localparam int T_W        = 32;
    localparam int T_FRAC     = 16;

    localparam int COORD_WIDTH_DEF = 20;

    localparam logic [T_W-1:0] MIN_DIST_RESET = 32'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER   = 3'd0,
        REG_EDGE_A   = 3'd1,
        REG_EDGE_B   = 3'd2,
        REG_NORMAL   = 3'd3,
        REG_LEN_A    = 3'd4,
        REG_LEN_B    = 3'd5,
        REG_MIN_DIST = 3'd6
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: src/rri_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// ovf is set when the quotient does not fit in QB bits.
module rri_div #(
    parameter int DW = 64,
    parameter int VW = 32,
    parameter int QB = 32,
    parameter int SW = 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] quot,
    output logic          ovf,
    output logic          rem_nz,
    output logic [SW-1:0] out_side
);

    localparam int HW  = DW - QB;
    localparam int CMW = (HW > VW) ? HW : VW;

    logic          valid_reg [QB+1];
    logic [VW-1:0] rem_reg   [QB+1];
    logic [QB-1:0] low_reg   [QB+1];
    logic [QB-1:0] quot_reg  [QB+1];
    logic [VW-1:0] div_reg   [QB+1];
    logic          ovf_reg   [QB+1];
    logic [SW-1:0] side_reg  [QB+1];

    logic [CMW-1:0] hi_ext;
    logic [CMW-1:0] dv_ext;
    logic           entry_ovf;

    assign hi_ext    = CMW'(dividend[DW-1:QB]);
    assign dv_ext    = CMW'(divisor);
    assign entry_ovf = (hi_ext >= dv_ext);

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= entry_ovf ? '0 : VW'(hi_ext);
        low_reg[0]  <= dividend[QB-1:0];
        quot_reg[0] <= '0;
        div_reg[0]  <= divisor;
        ovf_reg[0]  <= entry_ovf;
        side_reg[0] <= in_side;
    end

    for (genvar g = 0; g < QB; g++)
    begin : g_stage
        logic [VW:0]   trial;
        logic          ge;
        logic [VW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[g], low_reg[g][QB-1]};
            ge       = (trial >= {1'b0, div_reg[g]});
            rem_next = ge ? VW'(trial - {1'b0, div_reg[g]}) : trial[VW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= rem_next;
            low_reg[g+1]  <= {low_reg[g][QB-2:0], 1'b0};
            quot_reg[g+1] <= {quot_reg[g][QB-2:0], ge};
            div_reg[g+1]  <= div_reg[g];
            ovf_reg[g+1]  <= ovf_reg[g];
            side_reg[g+1] <= side_reg[g];
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = quot_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign rem_nz    = (rem_reg[QB] != '0);
    assign out_side  = side_reg[QB];

endmodule

`default_nettype wire

FILE: src/rri_front.sv
`default_nettype none

// Dot products, sign fold and numerator * direction, five register stages.
module rri_front
    import rri_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [CW-1:0]          org    [3],
    input  logic signed [CW-1:0]          dir    [3],
    input  logic signed [CW-1:0]          corner [3],
    input  logic signed [CW-1:0]          normal [3],
    output logic                          out_valid,
    output logic                          out_miss,
    output logic signed [CW-1:0]          out_org [3],
    output logic                          out_neg [3],
    output logic [2*CW+2+T_FRAC:0]        t_dividend,
    output logic [2*CW+1:0]               t_divisor,
    output logic [3*CW+4:0]               h_dividend [3],
    output logic [2*CW+2:0]               h_divisor
);

    localparam int NUMW = 2*CW + 3;
    localparam int DENW = 2*CW + 2;
    localparam int LO_W = (NUMW + 1) / 2;
    localparam int HI_W = NUMW - LO_W;
    localparam int PW   = NUMW + CW;
    localparam int HXW  = PW + 2;

    // stage 1: per-axis products
    logic                   s1_valid_reg;
    logic signed [2*CW:0]   s1_cn_reg  [3];
    logic signed [2*CW-1:0] s1_dn_reg  [3];
    logic signed [CW-1:0]   s1_org_reg [3];
    logic signed [CW-1:0]   s1_dir_reg [3];

    // stage 2: sums
    logic                   s2_valid_reg;
    logic signed [NUMW-1:0] s2_num_reg;
    logic signed [DENW-1:0] s2_den_reg;
    logic signed [CW-1:0]   s2_org_reg [3];
    logic signed [CW-1:0]   s2_dir_reg [3];

    // stage 3: fold sign of denominator
    logic                   s3_valid_reg;
    logic                   s3_miss_reg;
    logic [NUMW-1:0]        s3_mag_reg;
    logic [DENW-1:0]        s3_ud_reg;
    logic signed [CW-1:0]   s3_org_reg [3];
    logic signed [CW-1:0]   s3_dir_reg [3];

    // stage 4: partial products of num * |dir|
    logic                   s4_valid_reg;
    logic                   s4_miss_reg;
    logic [NUMW-1:0]        s4_mag_reg;
    logic [DENW-1:0]        s4_ud_reg;
    logic signed [CW-1:0]   s4_org_reg [3];
    logic                   s4_neg_reg [3];
    logic [LO_W+CW-1:0]     s4_pl_reg  [3];
    logic [HI_W+CW-1:0]     s4_ph_reg  [3];

    // stage 5: divider operands
    logic                   s5_valid_reg;
    logic                   s5_miss_reg;
    logic signed [CW-1:0]   s5_org_reg [3];
    logic                   s5_neg_reg [3];
    logic [NUMW+T_FRAC-1:0] s5_tx_reg;
    logic [DENW-1:0]        s5_ud_reg;
    logic [HXW-1:0]         s5_hx_reg  [3];
    logic [DENW:0]          s5_hy_reg;

    logic signed [2*CW:0]   cn_next [3];
    logic signed [2*CW-1:0] dn_next [3];
    logic signed [NUMW-1:0] num_next;
    logic signed [DENW-1:0] den_next;
    logic signed [NUMW-1:0] num_f;
    logic signed [DENW-1:0] den_f;
    logic                   miss_next;
    logic [LO_W+CW-1:0]     pl_next [3];
    logic [HI_W+CW-1:0]     ph_next [3];
    logic [HXW-1:0]         hx_next [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        logic signed [CW:0]     diff;
        logic signed [2*CW:0]   diff_w;
        logic signed [2*CW:0]   nrm_w;
        logic signed [2*CW-1:0] dir_w;
        logic signed [2*CW-1:0] nrm_n;
        logic [CW-1:0]          dabs;
        logic [PW-1:0]          prod;

        assign diff    = {corner[g][CW-1], corner[g]} - {org[g][CW-1], org[g]};
        assign diff_w  = {{CW{diff[CW]}}, diff};
        assign nrm_w   = {{(CW+1){normal[g][CW-1]}}, normal[g]};
        assign dir_w   = {{CW{dir[g][CW-1]}}, dir[g]};
        assign nrm_n   = {{CW{normal[g][CW-1]}}, normal[g]};
        assign cn_next[g] = diff_w * nrm_w;
        assign dn_next[g] = dir_w * nrm_n;

        // most negative direction wraps onto its own magnitude
        assign dabs = s3_dir_reg[g][CW-1] ? CW'(-s3_dir_reg[g]) : s3_dir_reg[g];
        assign pl_next[g] = (LO_W+CW)'(s3_mag_reg[LO_W-1:0]) * (LO_W+CW)'(dabs);
        assign ph_next[g] = (HI_W+CW)'(s3_mag_reg[NUMW-1:LO_W]) * (HI_W+CW)'(dabs);

        assign prod = (PW'(s4_ph_reg[g]) << LO_W) + PW'(s4_pl_reg[g]);
        // 2*|num*d| + den, divided later by 2*den, rounds half away from zero
        assign hx_next[g] = {1'b0, prod, 1'b0} + HXW'(s4_ud_reg);
    end

    always_comb
    begin
        num_next = {{2{s1_cn_reg[0][2*CW]}}, s1_cn_reg[0]}
                 + {{2{s1_cn_reg[1][2*CW]}}, s1_cn_reg[1]}
                 + {{2{s1_cn_reg[2][2*CW]}}, s1_cn_reg[2]};
        den_next = {{2{s1_dn_reg[0][2*CW-1]}}, s1_dn_reg[0]}
                 + {{2{s1_dn_reg[1][2*CW-1]}}, s1_dn_reg[1]}
                 + {{2{s1_dn_reg[2][2*CW-1]}}, s1_dn_reg[2]};
        num_f     = s2_den_reg[DENW-1] ? -s2_num_reg : s2_num_reg;
        den_f     = s2_den_reg[DENW-1] ? -s2_den_reg : s2_den_reg;
        miss_next = (s2_den_reg == '0) || num_f[NUMW-1] || (num_f == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_cn_reg[i]  <= cn_next[i];
            s1_dn_reg[i]  <= dn_next[i];
            s1_org_reg[i] <= org[i];
            s1_dir_reg[i] <= dir[i];
            s2_org_reg[i] <= s1_org_reg[i];
            s2_dir_reg[i] <= s1_dir_reg[i];
            s3_org_reg[i] <= s2_org_reg[i];
            s3_dir_reg[i] <= s2_dir_reg[i];
            s4_org_reg[i] <= s3_org_reg[i];
            s4_neg_reg[i] <= s3_dir_reg[i][CW-1];
            s4_pl_reg[i]  <= pl_next[i];
            s4_ph_reg[i]  <= ph_next[i];
            s5_org_reg[i] <= s4_org_reg[i];
            s5_neg_reg[i] <= s4_neg_reg[i];
            s5_hx_reg[i]  <= hx_next[i];
        end
        s2_num_reg  <= num_next;
        s2_den_reg  <= den_next;
        s3_miss_reg <= miss_next;
        s3_mag_reg  <= num_f;
        s3_ud_reg   <= den_f;
        s4_miss_reg <= s3_miss_reg;
        s4_mag_reg  <= s3_mag_reg;
        s4_ud_reg   <= s3_ud_reg;
        s5_miss_reg <= s4_miss_reg;
        s5_tx_reg   <= {s4_mag_reg, {T_FRAC{1'b0}}};
        s5_ud_reg   <= s4_ud_reg;
        s5_hy_reg   <= {s4_ud_reg, 1'b0};
    end

    assign out_valid  = s5_valid_reg;
    assign out_miss   = s5_miss_reg;
    assign out_org    = s5_org_reg;
    assign out_neg    = s5_neg_reg;
    assign t_dividend = s5_tx_reg;
    assign t_divisor  = s5_ud_reg;
    assign h_dividend = s5_hx_reg;
    assign h_divisor  = s5_hy_reg;

endmodule

`default_nettype wire

FILE: src/ray_rectangle_intersect_top.sv
`default_nettype none

// Ray / rectangle intersection tester. One ray beat is taken on every cycle
// in which start is high (busy never rises: the pipeline always moves), and
// exactly one result beat comes out for each, flagged by a one-cycle
// done pulse. The receiver cannot hold results off, so sample on done.
// A ray passes through five front stages (dot products, sign fold, num*dir
// partial products), the 33 stages of the bit-per-stage dividers that give
// t and the three hit-point offsets in parallel, and three back stages
// (saturate, edge products, span check). Throughput is one ray per cycle.
// The rectangle registers may only be written while no ray is in flight.
module ray_rectangle_intersect_top
    import rri_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,

    // ray beat
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,

    // register writes
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_addr,
    input  logic [CFG_W-1:0]              cfg_wdata,

    // result beat
    output logic                          done,
    output logic                          is_hit,
    output logic [T_W-1:0]                distance,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y,
    output logic signed [COORD_WIDTH-1:0] hit_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int PKW  = 3 * CW;
    localparam int NUMW = 2*CW + 3;
    localparam int DENW = 2*CW + 2;
    localparam int HXW  = NUMW + CW + 2;
    localparam int DAW  = 2*CW + 3;
    localparam int CMPW = DAW + LEN_W;
    localparam int SIDW = 1 + 3*CW;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] corner_reg;
    logic [CFG_W-1:0] edge_a_reg;
    logic [CFG_W-1:0] edge_b_reg;
    logic [CFG_W-1:0] normal_reg;
    logic [LEN_W-1:0] len_a_reg;
    logic [LEN_W-1:0] len_b_reg;
    logic [T_W-1:0]   min_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg   <= '0;
            edge_a_reg   <= '0;
            edge_b_reg   <= '0;
            normal_reg   <= '0;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            min_dist_reg <= MIN_DIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_CORNER:   corner_reg   <= cfg_wdata;
                REG_EDGE_A:   edge_a_reg   <= cfg_wdata;
                REG_EDGE_B:   edge_b_reg   <= cfg_wdata;
                REG_NORMAL:   normal_reg   <= cfg_wdata;
                REG_LEN_A:    len_a_reg    <= cfg_wdata[LEN_W-1:0];
                REG_LEN_B:    len_b_reg    <= cfg_wdata[LEN_W-1:0];
                REG_MIN_DIST: min_dist_reg <= cfg_wdata[T_W-1:0];
                default:      ;
            endcase
        end
    end

    // unpack: x in the highest field; fields past the register read as zero
    logic [PKW-1:0] corner_w, edge_a_w, edge_b_w, normal_w;
    logic signed [CW-1:0] corner_v [3];
    logic signed [CW-1:0] edge_a_v [3];
    logic signed [CW-1:0] edge_b_v [3];
    logic signed [CW-1:0] normal_v [3];
    logic signed [CW-1:0] org_v    [3];
    logic signed [CW-1:0] dir_v    [3];

    assign corner_w = PKW'(corner_reg);
    assign edge_a_w = PKW'(edge_a_reg);
    assign edge_b_w = PKW'(edge_b_reg);
    assign normal_w = PKW'(normal_reg);

    for (genvar g = 0; g < 3; g++)
    begin : g_unpack
        assign corner_v[g] = corner_w[(2-g)*CW +: CW];
        assign edge_a_v[g] = edge_a_w[(2-g)*CW +: CW];
        assign edge_b_v[g] = edge_b_w[(2-g)*CW +: CW];
        assign normal_v[g] = normal_w[(2-g)*CW +: CW];
    end

    assign org_v[0] = origin_x;
    assign org_v[1] = origin_y;
    assign org_v[2] = origin_z;
    assign dir_v[0] = dir_x;
    assign dir_v[1] = dir_y;
    assign dir_v[2] = dir_z;

    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Front end: N, D, |N|*dir
    // ---------------------------------------------------------------
    logic                    f_valid;
    logic                    f_miss;
    logic signed [CW-1:0]    f_org [3];
    logic                    f_neg [3];
    logic [NUMW+T_FRAC-1:0]  f_tx;
    logic [DENW-1:0]         f_ty;
    logic [HXW-1:0]          f_hx [3];
    logic [DENW:0]           f_hy;

    rri_front #(
        .CW(CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .org        (org_v),
        .dir        (dir_v),
        .corner     (corner_v),
        .normal     (normal_v),
        .out_valid  (f_valid),
        .out_miss   (f_miss),
        .out_org    (f_org),
        .out_neg    (f_neg),
        .t_dividend (f_tx),
        .t_divisor  (f_ty),
        .h_dividend (f_hx),
        .h_divisor  (f_hy)
    );

    // ---------------------------------------------------------------
    // Dividers: t in Q16.16, and rounded offsets along each axis
    // ---------------------------------------------------------------
    logic            d_valid;
    logic [T_W-1:0]  t_q;
    logic            t_ovf;
    logic            t_rnz;
    logic [SIDW-1:0] t_side;
    logic [T_W-1:0]  h_q   [3];
    logic            h_ovf [3];
    logic            h_neg [3];

    rri_div #(
        .DW(NUMW + T_FRAC),
        .VW(DENW),
        .QB(T_W),
        .SW(SIDW)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dividend  (f_tx),
        .divisor   (f_ty),
        .in_side   ({f_miss, f_org[0], f_org[1], f_org[2]}),
        .out_valid (d_valid),
        .quot      (t_q),
        .ovf       (t_ovf),
        .rem_nz    (t_rnz),
        .out_side  (t_side)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_hdiv
        logic h_valid_unused;
        logic h_rnz_unused;

        rri_div #(
            .DW(HXW),
            .VW(DENW + 1),
            .QB(T_W),
            .SW(1)
        ) u_hdiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (f_valid),
            .dividend  (f_hx[g]),
            .divisor   (f_hy),
            .in_side   (f_neg[g]),
            .out_valid (h_valid_unused),
            .quot      (h_q[g]),
            .ovf       (h_ovf[g]),
            .rem_nz    (h_rnz_unused),
            .out_side  (h_neg[g])
        );
    end

    // ---------------------------------------------------------------
    // Back end stage A: hit point, minimum distance test
    // ---------------------------------------------------------------
    logic                 a_valid_reg;
    logic                 a_above_reg;
    logic [T_W-1:0]       a_t_reg;
    logic signed [CW-1:0] a_p_reg [3];
    logic signed [CW-1:0] d_org [3];
    logic                 d_miss;
    logic                 above_next;
    logic signed [CW-1:0] p_next [3];

    assign d_miss   = t_side[SIDW-1];
    assign d_org[0] = t_side[3*CW-1:2*CW];
    assign d_org[1] = t_side[2*CW-1:CW];
    assign d_org[2] = t_side[CW-1:0];

    // t at or past 65536 always clears the minimum
    assign above_next = !d_miss
                     && (t_ovf || (t_q > min_dist_reg)
                         || ((t_q == min_dist_reg) && t_rnz));

    for (genvar g = 0; g < 3; g++)
    begin : g_point
        logic [CW:0]          off;
        logic signed [CW+2:0] off_s;
        logic signed [CW+2:0] sum;

        // anything from 2^CW up saturates the same way
        assign off   = (h_ovf[g] || (h_q[g] >= (T_W)'(1 << CW)))
                     ? {1'b1, {CW{1'b0}}} : h_q[g][CW:0];
        assign off_s = h_neg[g] ? -{2'b00, off} : {2'b00, off};
        assign sum   = {{3{d_org[g][CW-1]}}, d_org[g]} + off_s;

        always_comb
        begin
            if (sum[CW+2] && (sum[CW+2:CW-1] != '1))
                p_next[g] = {1'b1, {(CW-1){1'b0}}};
            else if (!sum[CW+2] && (sum[CW+2:CW-1] != '0))
                p_next[g] = {1'b0, {(CW-1){1'b1}}};
            else
                p_next[g] = sum[CW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage B: (p - c) . edge products
    // ---------------------------------------------------------------
    logic                  b_valid_reg;
    logic                  b_above_reg;
    logic [T_W-1:0]        b_t_reg;
    logic signed [CW-1:0]  b_p_reg  [3];
    logic signed [2*CW:0]  b_pa_reg [3];
    logic signed [2*CW:0]  b_pb_reg [3];
    logic signed [2*CW:0]  pa_next  [3];
    logic signed [2*CW:0]  pb_next  [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_edge
        logic signed [CW:0]   e;
        logic signed [2*CW:0] e_w;
        logic signed [2*CW:0] ea_w;
        logic signed [2*CW:0] eb_w;

        assign e    = {a_p_reg[g][CW-1], a_p_reg[g]} - {corner_v[g][CW-1], corner_v[g]};
        assign e_w  = {{CW{e[CW]}}, e};
        assign ea_w = {{(CW+1){edge_a_v[g][CW-1]}}, edge_a_v[g]};
        assign eb_w = {{(CW+1){edge_b_v[g][CW-1]}}, edge_b_v[g]};
        assign pa_next[g] = e_w * ea_w;
        assign pb_next[g] = e_w * eb_w;
    end

    // ---------------------------------------------------------------
    // Stage C: span checks, result register
    // ---------------------------------------------------------------
    logic signed [DAW-1:0] da;
    logic signed [DAW-1:0] db;
    logic                  span_ok;

    assign da = {{2{b_pa_reg[0][2*CW]}}, b_pa_reg[0]}
              + {{2{b_pa_reg[1][2*CW]}}, b_pa_reg[1]}
              + {{2{b_pa_reg[2][2*CW]}}, b_pa_reg[2]};
    assign db = {{2{b_pb_reg[0][2*CW]}}, b_pb_reg[0]}
              + {{2{b_pb_reg[1][2*CW]}}, b_pb_reg[1]}
              + {{2{b_pb_reg[2][2*CW]}}, b_pb_reg[2]};
    assign span_ok = !da[DAW-1] && (CMPW'($unsigned(da)) <= CMPW'(len_a_reg))
                  && !db[DAW-1] && (CMPW'($unsigned(db)) <= CMPW'(len_b_reg));

    logic                 done_reg;
    logic                 is_hit_reg;
    logic [T_W-1:0]       distance_reg;
    logic signed [CW-1:0] hit_reg [3];
    logic                 hit_next;

    assign hit_next = b_above_reg && span_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= d_valid;
            b_valid_reg <= a_valid_reg;
            done_reg    <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_above_reg  <= above_next;
        a_t_reg      <= t_ovf ? '1 : t_q;
        b_above_reg  <= a_above_reg;
        b_t_reg      <= a_t_reg;
        is_hit_reg   <= hit_next;
        distance_reg <= hit_next ? b_t_reg : '0;
        for (int i = 0; i < 3; i++)
        begin
            a_p_reg[i]  <= p_next[i];
            b_p_reg[i]  <= a_p_reg[i];
            b_pa_reg[i] <= pa_next[i];
            b_pb_reg[i] <= pb_next[i];
            hit_reg[i]  <= hit_next ? b_p_reg[i] : '0;
        end
    end

    assign done     = done_reg;
    assign is_hit   = is_hit_reg;
    assign distance = distance_reg;
    assign hit_x    = hit_reg[0];
    assign hit_y    = hit_reg[1];
    assign hit_z    = hit_reg[2];

endmodule

`default_nettype wire

FILE: bench/ray_rectangle_intersect_top_tb.sv
`default_nettype none

module ray_rectangle_intersect_top_tb;
    import rri_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int LATENCY   = 41;
    localparam int SETTLE    = LATENCY + 8;
    localparam int CYCLE_CAP = 600000;
    localparam longint C_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint C_MIN = -C_MAX - 1;

    typedef enum logic [1:0] {
        K_RAY,
        K_CFG,
        K_DRAIN,
        K_PHASE
    } job_kind_t;

    // one pending job for the driver: a ray beat, a register write,
    // a pause until the pipe is empty, or a change of sender idle rate
    typedef struct {
        job_kind_t               kind;
        cfg_idx_t                idx;
        logic [CFG_W-1:0]        data;
        logic signed [CW-1:0]    org [3];
        logic signed [CW-1:0]    dir [3];
    } job_t;

    typedef struct packed {
        logic                    is_hit;
        logic [T_W-1:0]          distance;
        logic signed [CW-1:0]    hx;
        logic signed [CW-1:0]    hy;
        logic signed [CW-1:0]    hz;
    } hit_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CW-1:0]  origin_x, origin_y, origin_z;
    logic signed [CW-1:0]  dir_x, dir_y, dir_z;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  done;
    logic                  is_hit;
    logic [T_W-1:0]        distance;
    logic signed [CW-1:0]  hit_x, hit_y, hit_z;

    ray_rectangle_intersect_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .is_hit    (is_hit),
        .distance  (distance),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z)
    );

    job_t   jobs[$];        // work for the driver, filled up front
    hit_t   hits_due[$];    // predicted result beats, oldest first
    int     errors = 0;
    int     cycles = 0;
    int     idle_pct = 0;
    int     hold = 0;
    logic   taken = 1'b0;   // last edge moved a ray beat

    // shadow copy of the rectangle registers
    logic [CFG_W-1:0] m_corner, m_edge_a, m_edge_b, m_normal;
    logic [LEN_W-1:0] m_len_a, m_len_b;
    logic [T_W-1:0]   m_min;

    // geometry of the current aligned rectangle, used to aim rays
    longint g_c[3], g_a[3], g_b[3];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: t = ((c - o).n) / (dir.n), sign folded into the
    // numerator, Q16.16 by long division; hit point rounded half away
    // from zero and clamped; then both edge spans checked on the
    // clamped point. Anything else gives an all-zero miss beat.
    // ------------------------------------------------------------------
    function automatic hit_t trace_ray(input job_t r);
        longint     c[3], n[3], ea[3], eb[3], p[3];
        longint     num, den, da, db, prod, so, ov;
        bit [63:0]  un, ud, q, rem, frac, tq, mag, off;
        bit         above;
        hit_t       res;
        int         sh;
        res = '0;
        num = 0;
        den = 0;
        da  = 0;
        db  = 0;
        for (int k = 0; k < 3; k++)
        begin
            sh    = (2 - k) * CW;
            c[k]  = longint'($signed(m_corner[sh +: CW]));
            n[k]  = longint'($signed(m_normal[sh +: CW]));
            ea[k] = longint'($signed(m_edge_a[sh +: CW]));
            eb[k] = longint'($signed(m_edge_b[sh +: CW]));
            num  += (c[k] - longint'(r.org[k])) * n[k];
            den  += longint'(r.dir[k]) * n[k];
        end
        if (den == 0)
            return res;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return res;
        un  = num;
        ud  = den;
        q   = un / ud;
        rem = un % ud;
        if (q >= (64'd1 << T_FRAC))
        begin
            tq    = 64'hFFFF_FFFF;
            above = 1'b1;
        end
        else
        begin
            frac = 0;
            for (int i = 0; i < T_FRAC; i++)
            begin
                rem  = rem << 1;
                frac = frac << 1;
                if (rem >= ud)
                begin
                    rem  = rem - ud;
                    frac = frac | 64'd1;
                end
            end
            tq    = (q << T_FRAC) | frac;
            above = (tq > m_min) || (tq == m_min && rem != 0);
        end
        if (!above)
            return res;
        for (int k = 0; k < 3; k++)
        begin
            prod = num * longint'(r.dir[k]);
            mag  = (prod < 0) ? -prod : prod;
            off  = ((mag << 1) + ud) / (ud << 1);
            so   = (prod < 0) ? -longint'(off) : longint'(off);
            ov   = longint'(r.org[k]) + so;
            p[k] = (ov > C_MAX) ? C_MAX : (ov < C_MIN) ? C_MIN : ov;
            da  += (p[k] - c[k]) * ea[k];
            db  += (p[k] - c[k]) * eb[k];
        end
        if (da < 0 || da > longint'(m_len_a) || db < 0 || db > longint'(m_len_b))
            return res;
        res.is_hit   = 1'b1;
        res.distance = tq[T_W-1:0];
        res.hx       = p[0][CW-1:0];
        res.hy       = p[1][CW-1:0];
        res.hz       = p[2][CW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [CFG_W-1:0] pack3(input longint x, input longint y,
                                               input longint z);
        logic [CW-1:0] px, py, pz;
        px = x[CW-1:0];
        py = y[CW-1:0];
        pz = z[CW-1:0];
        return {px, py, pz};
    endfunction

    task automatic add_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
        job_t j;
        j = '{kind: K_CFG, idx: REG_CORNER, default: '0};
        j.kind = K_CFG;
        j.idx  = idx;
        j.data = v;
        jobs.push_back(j);
    endtask

    task automatic add_mark(input job_kind_t kind, input int v);
        job_t j;
        j = '{kind: K_RAY, idx: REG_CORNER, default: '0};
        j.kind = kind;
        j.data = CFG_W'(v);
        jobs.push_back(j);
    endtask

    task automatic add_ray(input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz);
        job_t j;
        j = '{kind: K_RAY, idx: REG_CORNER, default: '0};
        j.kind   = K_RAY;
        j.org[0] = ox[CW-1:0];
        j.org[1] = oy[CW-1:0];
        j.org[2] = oz[CW-1:0];
        j.dir[0] = dx[CW-1:0];
        j.dir[1] = dy[CW-1:0];
        j.dir[2] = dz[CW-1:0];
        jobs.push_back(j);
    endtask

    // axis-aligned rectangle with random side lengths, normal on one axis
    task automatic set_aligned_rect();
        int     ax, e1, e2;
        longint l1, l2, nz;
        ax = $urandom_range(2);
        e1 = (ax + 1) % 3;
        e2 = (ax + 2) % 3;
        l1 = $urandom_range(8192, 64);
        l2 = $urandom_range(8192, 64);
        nz = $urandom_range(1) ? 1024 : -1024;
        for (int k = 0; k < 3; k++)
        begin
            g_c[k] = longint'($urandom_range(16384)) - 8192;
            g_a[k] = 0;
            g_b[k] = 0;
        end
        g_a[e1] = $urandom_range(1) ? l1 : -l1;
        g_b[e2] = $urandom_range(1) ? l2 : -l2;
        add_cfg(REG_CORNER, pack3(g_c[0], g_c[1], g_c[2]));
        add_cfg(REG_EDGE_A, pack3(g_a[0], g_a[1], g_a[2]));
        add_cfg(REG_EDGE_B, pack3(g_b[0], g_b[1], g_b[2]));
        add_cfg(REG_NORMAL, pack3(ax == 0 ? nz : 0, ax == 1 ? nz : 0, ax == 2 ? nz : 0));
        add_cfg(REG_LEN_A, CFG_W'(l1 * l1));
        add_cfg(REG_LEN_B, CFG_W'(l2 * l2));
        case ($urandom_range(3))
            0: add_cfg(REG_MIN_DIST, '0);
            1: add_cfg(REG_MIN_DIST, CFG_W'(MIN_DIST_RESET));
            2: add_cfg(REG_MIN_DIST, CFG_W'($urandom_range(32'h2_0000)));
            default: add_cfg(REG_MIN_DIST, CFG_W'($urandom_range(32'h8000, 32'h2_0000)));
        endcase
    endtask

    task automatic set_random_regs();
        add_cfg(REG_CORNER, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_EDGE_A, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_EDGE_B, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_NORMAL, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_LEN_A, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_LEN_B, CFG_W'({$urandom(), $urandom()}));
        add_cfg(REG_MIN_DIST,
                CFG_W'($urandom_range(1) ? $urandom() : $urandom_range(32'h4_0000)));
    endtask

    // ray through a point near the rectangle, from a random origin
    task automatic add_aimed_ray();
        longint tg[3], o[3], d[3];
        longint u, v, s;
        u = longint'($urandom_range(140)) - 20;
        v = longint'($urandom_range(140)) - 20;
        s = $urandom_range(8, 1);
        for (int k = 0; k < 3; k++)
        begin
            tg[k] = g_c[k] + (g_a[k] * u) / 100 + (g_b[k] * v) / 100;
            o[k]  = tg[k] + longint'($urandom_range(40000)) - 20000;
            d[k]  = ((tg[k] - o[k]) * s) / 4;
        end
        add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    task automatic add_noise_ray();
        add_ray(longint'($urandom()), longint'($urandom()), longint'($urandom()),
                longint'($urandom()), longint'($urandom()), longint'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Driver: works at the falling edge. A ray beat stays up until the
    // edge that takes it; register writes go out one per cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic   s;
        logic   w;
        job_t   j;
        s = start;
        w = 1'b0;
        if (rst_n)
        begin
            if (!(start && !taken))
            begin
                s = 1'b0;
                if (hold > 0)
                    hold--;
                else if (jobs.size() > 0)
                begin
                    j = jobs[0];
                    case (j.kind)
                        K_RAY:
                        begin
                            if ($urandom_range(99) >= idle_pct)
                            begin
                                origin_x <= j.org[0];
                                origin_y <= j.org[1];
                                origin_z <= j.org[2];
                                dir_x    <= j.dir[0];
                                dir_y    <= j.dir[1];
                                dir_z    <= j.dir[2];
                                s = 1'b1;
                                void'(jobs.pop_front());
                            end
                        end
                        K_CFG:
                        begin
                            cfg_addr  <= j.idx;
                            cfg_wdata <= j.data;
                            w = 1'b1;
                            void'(jobs.pop_front());
                        end
                        K_DRAIN:
                        begin
                            // nothing may be in flight across a register write
                            if (hits_due.size() == 0)
                            begin
                                hold = SETTLE;
                                void'(jobs.pop_front());
                            end
                        end
                        default:
                        begin
                            idle_pct = int'(j.data);
                            void'(jobs.pop_front());
                        end
                    endcase
                end
            end
        end
        start  <= s;
        cfg_we <= w;
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest prediction,
    // tracks register writes and predicts each accepted ray beat.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hit_t   want;
        job_t   r;
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (hits_due.size() == 0)
                    report_mismatch("unexpected beat", is_hit, 0);
                else
                begin
                    want = hits_due.pop_front();
                    if (is_hit !== want.is_hit)
                        report_mismatch("is_hit", is_hit, want.is_hit);
                    if (distance !== want.distance)
                        report_mismatch("distance", distance, want.distance);
                    if (hit_x !== want.hx)
                        report_mismatch("hit_x", hit_x, want.hx);
                    if (hit_y !== want.hy)
                        report_mismatch("hit_y", hit_y, want.hy);
                    if (hit_z !== want.hz)
                        report_mismatch("hit_z", hit_z, want.hz);
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    REG_CORNER:   m_corner = cfg_wdata;
                    REG_EDGE_A:   m_edge_a = cfg_wdata;
                    REG_EDGE_B:   m_edge_b = cfg_wdata;
                    REG_NORMAL:   m_normal = cfg_wdata;
                    REG_LEN_A:    m_len_a  = cfg_wdata[LEN_W-1:0];
                    REG_LEN_B:    m_len_b  = cfg_wdata[LEN_W-1:0];
                    REG_MIN_DIST: m_min    = cfg_wdata[T_W-1:0];
                    default: ;
                endcase
            end
            taken <= start && !busy;
            if (start && !busy)
            begin
                r = '{kind: K_RAY, idx: REG_CORNER, default: '0};
                r.org[0] = origin_x;
                r.org[1] = origin_y;
                r.org[2] = origin_z;
                r.dir[0] = dir_x;
                r.dir[1] = dir_y;
                r.dir[2] = dir_z;
                hits_due.push_back(trace_ray(r));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        int pcts[8];
        pcts = '{0, 87, 0, 32, 87, 0, 32, 87};
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        origin_x  = '0;
        origin_y  = '0;
        origin_z  = '0;
        dir_x     = '0;
        dir_y     = '0;
        dir_z     = '0;
        m_corner  = '0;
        m_edge_a  = '0;
        m_edge_b  = '0;
        m_normal  = '0;
        m_len_a   = '0;
        m_len_b   = '0;
        m_min     = MIN_DIST_RESET;

        // registers at reset: zero normal, so every ray misses
        add_ray(1024, 2048, 5120, 0, 0, -1024);
        add_ray(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);

        // 4 x 4 square in the z = 0 plane, normal +z
        add_mark(K_DRAIN, 0);
        add_cfg(REG_CORNER, pack3(0, 0, 0));
        add_cfg(REG_EDGE_A, pack3(4096, 0, 0));
        add_cfg(REG_EDGE_B, pack3(0, 4096, 0));
        add_cfg(REG_NORMAL, pack3(0, 0, 1024));
        add_cfg(REG_LEN_A, CFG_W'(64'd1 << 24));
        add_cfg(REG_LEN_B, CFG_W'(64'd1 << 24));
        add_cfg(REG_MIN_DIST, CFG_W'(MIN_DIST_RESET));
        add_ray(2048, 2048, 5120, 0, 0, -1024);     // centre hit, t = 5
        add_ray(0, 0, 5120, 0, 0, -1024);           // on the corner
        add_ray(4096, 4096, 5120, 0, 0, -1024);     // far corner, span limit
        add_ray(4097, 2048, 5120, 0, 0, -1024);     // just past edge a
        add_ray(2048, -1, 5120, 0, 0, -1024);       // just before edge b
        add_ray(2048, 2048, -5120, 0, 0, -1024);    // plane behind the ray
        add_ray(2048, 2048, 5120, 1024, 0, 0);      // parallel to the plane
        add_ray(2048, 2048, -5120, 0, 0, 1024);     // from below, positive D
        add_ray(1024, 1024, C_MAX, 0, 0, -1);       // huge t, distance saturates
        add_ray(0, 0, 5120, 3000, 2000, -1);        // hit point clamps, then miss
        add_ray(2048, 2048, 0, 0, 0, -1024);        // origin on plane, t = 0

        // minimum distance exactly on t, then just below it
        add_mark(K_DRAIN, 0);
        add_cfg(REG_MIN_DIST, CFG_W'(32'd5 << 16));
        add_ray(2048, 2048, 5120, 0, 0, -1024);     // t equals minimum: miss
        add_ray(2048, 2048, 5121, 0, 0, -1024);     // t just above the minimum: hit
        add_ray(2048, 2048, 5120, 0, 0, -1023);     // inexact quotient

        // extremes of every register
        add_mark(K_DRAIN, 0);
        for (int i = 0; i <= REG_MIN_DIST; i++)
            add_cfg(cfg_idx_t'(i), '1);
        add_ray(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        add_ray(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        add_ray(0, 0, 0, 1, 1, 1);
        add_mark(K_DRAIN, 0);
        add_cfg(REG_MIN_DIST, '0);
        add_cfg(REG_NORMAL, pack3(C_MAX, C_MIN, C_MAX));
        add_ray(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
        add_ray(-1, -1, -1, C_MIN, C_MAX, C_MIN);

        // random part: mostly rays aimed at an aligned rectangle
        for (int ph = 0; ph < 8; ph++)
        begin
            add_mark(K_DRAIN, 0);
            add_mark(K_PHASE, pcts[ph]);
            if (ph % 4 == 3)
                set_random_regs();
            else
                set_aligned_rect();
            for (int i = 0; i < 210; i++)
            begin
                if ($urandom_range(99) < 75)
                    add_aimed_ray();
                else
                    add_noise_ray();
                // let the pipe run dry once in the middle of each phase
                if (i == 100)
                    add_mark(K_DRAIN, 0);
            end
        end

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        while (jobs.size() > 0 || hits_due.size() > 0 || start)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/rri_pkg.sv
src/rri_div.sv
src/rri_front.sv
src/ray_rectangle_intersect_top.sv
bench/ray_rectangle_intersect_top_tb.sv
